[sv/brfp_pkg.sv]
// ----------------------------------------------------------------------------
// brfp_pkg: shared types and constants for the reply frame parser
// Parse phases, the fixed payload length and the ASCII tag and digit codes.
// ----------------------------------------------------------------------------
package brfp_pkg;

    // Payload length carried in the length byte
    localparam int unsigned PAYLOAD_LEN = 5;

    // Width of the slot index into the frame store
    localparam int unsigned IDX_W = 3;

    localparam logic [7:0] LEN_BYTE   = 8'(PAYLOAD_LEN);
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Parser phases
    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

endpackage

[sv/baud_reply_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// baud_reply_frame_parser_core: reply frame recognizer for received bytes
// Finds header, length, five payload bytes and an additive checksum, and
// reports the baud code of a good "CAN=" reply.
// ----------------------------------------------------------------------------
// Every received byte yields exactly one result (frame_ok, baud_code), in the
// cycle after the byte is transferred in; a byte can be transferred in every
// cycle unless in_stall holds it. The parser state, the payload bytes and a running checksum sit in
// registers, and the result lands in an output register, so a new byte is
// taken while the previous result still waits, as long as out_stall is low
// or the output register is empty. Write header_byte only while idle.
// ----------------------------------------------------------------------------
module baud_reply_frame_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       header_we,
    input  logic [7:0] header_byte,
    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_ok,
    output logic [7:0] baud_code
);

    localparam int unsigned LAST_IDX = brfp_pkg::PAYLOAD_LEN;

    brfp_pkg::phase_t               phase_reg, phase_next;
    logic [brfp_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [7:0]                     sum_reg, sum_next;
    logic [7:0]                     data_reg [1:LAST_IDX];
    logic                           data_we;
    logic [7:0]                     hdr_reg;
    logic                           out_valid_reg, out_valid_next;
    logic                           frame_ok_reg;
    logic [7:0]                     baud_code_reg;
    logic                           res_ok;
    logic [7:0]                     res_code;
    logic                           in_xfer;
    logic                           tag_ok;

    // Take a byte whenever the output register is free or being drained
    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // Header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 8'd0;
        end
        else if (header_we)
        begin
            hdr_reg <= header_byte;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            brfp_pkg::PH_HEAD:
            begin
                if (rx_byte == hdr_reg)
                begin
                    phase_next = brfp_pkg::PH_LEN;
                end
            end
            brfp_pkg::PH_LEN:
            begin
                phase_next = (rx_byte == brfp_pkg::LEN_BYTE) ? brfp_pkg::PH_DATA
                                                               : brfp_pkg::PH_HEAD;
            end
            brfp_pkg::PH_DATA:
            begin
                if (idx_reg >= brfp_pkg::IDX_W'(LAST_IDX))
                begin
                    phase_next = brfp_pkg::PH_SUM;
                end
            end
            brfp_pkg::PH_SUM:
            begin
                phase_next = brfp_pkg::PH_HEAD;
            end
            default:
            begin
                phase_next = brfp_pkg::PH_HEAD;
            end
        endcase
    end

    // Compare tag bytes against "CAN="
    assign tag_ok = (data_reg[1] == brfp_pkg::CHAR_C) && (data_reg[2] == brfp_pkg::CHAR_A)
                 && (data_reg[3] == brfp_pkg::CHAR_N) && (data_reg[4] == brfp_pkg::CHAR_EQ);

    // Datapath: slot index, running checksum, payload write and result
    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        data_we  = 1'b0;
        res_ok   = 1'b0;
        res_code = 8'd0;
        unique case (phase_reg)
            brfp_pkg::PH_HEAD:
            begin
                if (rx_byte == hdr_reg)
                begin
                    idx_next = '0;
                end
            end
            brfp_pkg::PH_LEN:
            begin
                if (rx_byte == brfp_pkg::LEN_BYTE)
                begin
                    idx_next = brfp_pkg::IDX_W'(1);
                    sum_next = rx_byte;
                end
            end
            brfp_pkg::PH_DATA:
            begin
                idx_next = idx_reg + brfp_pkg::IDX_W'(1);
                if (idx_reg <= brfp_pkg::IDX_W'(LAST_IDX) && idx_reg != '0)
                begin
                    data_we  = 1'b1;
                    sum_next = sum_reg + rx_byte;
                end
            end
            brfp_pkg::PH_SUM:
            begin
                if (rx_byte == sum_reg && tag_ok)
                begin
                    res_ok   = 1'b1;
                    res_code = data_reg[LAST_IDX] - brfp_pkg::CHAR_ZERO;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= brfp_pkg::PH_HEAD;
            idx_reg   <= '0;
            sum_reg   <= 8'd0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload store, one slot per payload byte
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= LAST_IDX; i++)
        begin
            if (in_xfer && data_we && idx_reg == brfp_pkg::IDX_W'(i))
            begin
                data_reg[i] <= rx_byte;
            end
        end
    end

    // Output register: load on input transfer, drop when taken
    always_comb
    begin
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            frame_ok_reg  <= res_ok;
            baud_code_reg <= res_code;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_ok  = frame_ok_reg;
    assign baud_code = baud_code_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty output register");

    a_sum_returns_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg == brfp_pkg::PH_SUM) |=> phase_reg == brfp_pkg::PH_HEAD)
        else $error("checksum byte did not return parser to header search");

    a_ok_only_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg != brfp_pkg::PH_SUM) |=> !frame_ok_reg)
        else $error("frame_ok raised outside checksum phase");

    a_data_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == brfp_pkg::PH_DATA |->
            (idx_reg != '0 && idx_reg <= brfp_pkg::IDX_W'(LAST_IDX)))
        else $error("payload slot index out of range");

    a_code_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_ok_reg) |-> baud_code_reg == 8'd0)
        else $error("baud_code nonzero without frame_ok");

endmodule

[bench/baud_reply_frame_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baud_reply_frame_parser_core_tb: self-checking bench for the reply parser
// Feeds received bytes through the input channel, predicts every result with
// a behavioral copy of the parser state, and compares each transferred result
// against the oldest prediction. Covers directed frames, header settings and
// random framed traffic under sender and receiver idling.
// ----------------------------------------------------------------------------
module baud_reply_frame_parser_core_tb;

    // Quiet cycles (nothing transferred on either side) before giving up
    localparam int unsigned QUIET_LIMIT = 2000;

    typedef struct packed {
        logic       ok;
        logic [7:0] code;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       header_we = 1'b0;
    logic [7:0] cfg_header = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       frame_ok;
    logic [7:0] baud_code;

    // Idle rates in percent for the byte sender and the result receiver
    int unsigned tx_idle_pct = 31;
    int unsigned rx_idle_pct = 84;

    // Predicted parser state
    brfp_pkg::phase_t phase_model = brfp_pkg::PH_HEAD;
    logic [2:0] slot_model = '0;
    logic [7:0] store_model [0:5] = '{default: 8'h00};
    logic [7:0] header_model = 8'h00;

    reply_t      pending_replies[$];
    int unsigned bytes_sent = 0;
    int unsigned error_count = 0;

    baud_reply_frame_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .header_we  (header_we),
        .header_byte(cfg_header),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_ok   (frame_ok),
        .baud_code  (baud_code)
    );

    always #5 clk = ~clk;

    // Advance the predicted parser by one byte and return its result
    function automatic reply_t parse_reply_byte(input logic [7:0] b);
        reply_t     r;
        logic [7:0] csum;
        r = '0;
        case (phase_model)
            brfp_pkg::PH_HEAD:
            begin
                if (b == header_model)
                begin
                    phase_model = brfp_pkg::PH_LEN;
                    slot_model  = '0;
                end
            end
            brfp_pkg::PH_LEN:
            begin
                // a wrong length drops back to search without a header check
                if (b == brfp_pkg::LEN_BYTE)
                begin
                    store_model[0] = b;
                    slot_model     = 3'd1;
                    phase_model    = brfp_pkg::PH_DATA;
                end
                else
                begin
                    phase_model = brfp_pkg::PH_HEAD;
                end
            end
            brfp_pkg::PH_DATA:
            begin
                if (slot_model < brfp_pkg::PAYLOAD_LEN)
                begin
                    store_model[slot_model] = b;
                    slot_model = slot_model + 3'd1;
                end
                else
                begin
                    // last payload byte; an index past the store is not kept
                    if (slot_model == brfp_pkg::PAYLOAD_LEN)
                        store_model[slot_model] = b;
                    slot_model  = slot_model + 3'd1;
                    phase_model = brfp_pkg::PH_SUM;
                end
            end
            default:
            begin
                csum = '0;
                foreach (store_model[i])
                    csum += store_model[i];
                if (b == csum && store_model[1] == brfp_pkg::CHAR_C &&
                    store_model[2] == brfp_pkg::CHAR_A &&
                    store_model[3] == brfp_pkg::CHAR_N &&
                    store_model[4] == brfp_pkg::CHAR_EQ)
                begin
                    r.ok   = 1'b1;
                    r.code = store_model[5] - brfp_pkg::CHAR_ZERO;
                end
                // the checksum byte never counts as a header
                phase_model = brfp_pkg::PH_HEAD;
            end
        endcase
        return r;
    endfunction

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Compare each transferred result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with no byte pending: frame_ok=%0d baud_code=0x%02h",
                       frame_ok, baud_code);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (frame_ok !== want.ok)
                begin
                    $error("frame_ok: expected %0d, got %0d", want.ok, frame_ok);
                    error_count++;
                end
                if (baud_code !== want.code)
                begin
                    $error("baud_code: expected 0x%02h, got 0x%02h", want.code, baud_code);
                    error_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Transfer one byte in, with a random gap first, and record its result
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(parse_reply_byte(b));
        bytes_sent++;
    endtask

    // Drop valid and hold until every predicted result has been transferred
    task automatic wait_replies_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_header(input logic [7:0] value);
        header_we  <= 1'b1;
        cfg_header <= value;
        @(posedge clk);
        header_we    <= 1'b0;
        header_model = value;
    endtask

    // Send header, length and, for a good length, payload and checksum;
    // csum_err is added to the true checksum
    task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] t0, t1, t2, t3,
                              input logic [7:0] digit, input logic [7:0] csum_err);
        logic [7:0] csum;
        csum = len_byte + t0 + t1 + t2 + t3 + digit;
        send_byte(header_model);
        send_byte(len_byte);
        if (len_byte != brfp_pkg::LEN_BYTE)
            return;
        send_byte(t0);
        send_byte(t1);
        send_byte(t2);
        send_byte(t3);
        send_byte(digit);
        send_byte(csum + csum_err);
    endtask

    // Header mismatch, then a good frame whose digit byte is 8'hFF, not a decimal digit
    task automatic test_reply_frames();
        send_byte(8'hFF);
        send_frame(brfp_pkg::LEN_BYTE, brfp_pkg::CHAR_C, brfp_pkg::CHAR_A,
                   brfp_pkg::CHAR_N, brfp_pkg::CHAR_EQ, 8'hFF, 8'h00);
    endtask

    // A repeated header is taken as a bad length, not as a new header
    task automatic test_bad_length();
        send_byte(header_model);
        send_byte(header_model);
        send_byte(brfp_pkg::LEN_BYTE);
    endtask

    // Header 8'hFF with a bad checksum equal to the header, then a header equal to the length byte and a wrong tag
    task automatic test_header_values();
        wait_replies_drained();
        load_header(8'hFF);
        send_frame(brfp_pkg::LEN_BYTE, brfp_pkg::CHAR_C, brfp_pkg::CHAR_A,
                   brfp_pkg::CHAR_N, brfp_pkg::CHAR_EQ, 8'h00, 8'hEB);
        wait_replies_drained();
        load_header(brfp_pkg::LEN_BYTE);
        send_frame(brfp_pkg::LEN_BYTE, brfp_pkg::CHAR_C, brfp_pkg::CHAR_A,
                   brfp_pkg::CHAR_N, 8'h3F, brfp_pkg::CHAR_ZERO + 8'd4, 8'h00);
    endtask

    // Mostly framed traffic with random content, plus noise and broken frames
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned n_bytes);
        int unsigned goal;
        int unsigned next_cfg;
        logic [7:0]  len_byte;
        logic [7:0]  tag [0:3];
        logic [7:0]  digit;
        logic [7:0]  csum_err;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal     = bytes_sent + n_bytes;
        next_cfg = bytes_sent;
        while (bytes_sent < goal)
        begin
            // change the header a few times per run, extremes included
            if (bytes_sent >= next_cfg)
            begin
                wait_replies_drained();
                case ($urandom_range(0, 3))
                    0: load_header(8'h00);
                    1: load_header(8'hFF);
                    default: load_header(8'($urandom));
                endcase
                next_cfg = bytes_sent + n_bytes / 3;
            end
            if ($urandom_range(0, 99) < 12)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom));
            end
            else
            begin
                len_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) : brfp_pkg::LEN_BYTE;
                tag = '{brfp_pkg::CHAR_C, brfp_pkg::CHAR_A, brfp_pkg::CHAR_N,
                        brfp_pkg::CHAR_EQ};
                if ($urandom_range(0, 3) == 0)
                    tag[$urandom_range(0, 3)] = 8'($urandom);
                digit = $urandom_range(0, 1)
                        ? brfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                        : 8'($urandom);
                csum_err = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(len_byte, tag[0], tag[1], tag[2], tag[3], digit, csum_err);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reply_frames();
        test_bad_length();
        test_header_values();
        test_random_traffic(31, 84, 330);
        test_random_traffic(84, 31, 330);
        test_random_traffic(0, 0, 340);
        wait_replies_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
